// ----- hdl/tlps_pkg.sv -----
// Shared types and constants of the three-level process scheduler.
`timescale 1ns / 1ps

package tlps_pkg;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_RUNNABLE = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_QUEUE    = 3'd3;
    localparam logic [2:0] ACT_TICKETS  = 3'd4;
    localparam logic [2:0] ACT_PRIO     = 3'd5;
    localparam logic [2:0] ACT_SCHED    = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // Packed process entry as stored in the table memory (used bit kept apart).
    typedef struct packed {
        logic [30:0] pid;
        logic        runnable;
        logic [1:0]  level;
        logic [15:0] tickets;
        logic [31:0] arrival;
        logic [31:0] runs;
        logic [19:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/tlps_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module tlps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/tlps_divider.sv -----
// Iterative 32-bit unsigned remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module tlps_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted   = {rem_reg, quo_reg[31]};
    assign diff      = shifted - {1'b0, div_reg};
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/three_level_process_scheduler_unit.sv -----
// Top level of the three-level process scheduler.
`timescale 1ns / 1ps
// Usage: items enter on s_axis (action, pid, value, now); each gives exactly one
// result item on m_axis (status, chosen_pid, chosen_level, slot). One item is
// processed at a time. The process table sits in a synchronous RAM of
// TABLE_ENTRIES words and every table walk reads one entry per cycle, but the
// ratio walk pauses at each eligible entry for the compare, so the RAM read port
// sets the time. Schedule walks the table up to three times: the ticket sum,
// then the lottery pick after the remainder step if the sum is nonzero, the
// first eligible entry if it is zero, or, when no level-0 entry is eligible,
// the ratio walk and, if that finds none, the priority walk.
// The ratio compare uses two 32x32 multiplies, registered before the compare.
// Used bits sit in flip-flops and are cleared at reset, so no clearing pass
// is needed. Reset also loads the lottery state with 1.
// A write on cfg loads cfg_data into the lottery state as seed; write it only
// while idle. The result register holds until m_axis_tready; s_axis_tready
// stays low until the result is taken, so a stalled receiver stalls input.
module three_level_process_scheduler_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], pid[33:3], value[49:34], now[81:50], zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], chosen_pid[32:2], chosen_level[34:33], slot[40:35], zero fill
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import tlps_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] LAST = (AW+1)'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FIND, S_SUM, S_DIV, S_LOT, S_RATIO, S_RCMP,
        S_PRIO, S_SELRD, S_SELWR, S_ADDWR, S_WRITE, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]  act_reg;
    logic [30:0] pid_reg;
    logic [15:0] val_reg;
    logic [31:0] now_reg;
    logic [AW:0] idx_reg;
    logic        rvld_reg;
    logic [AW-1:0] ridx_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [31:0] lfsr_reg;
    logic [31:0] sum_reg;
    logic [31:0] r_reg;
    logic        found_reg;
    logic [AW-1:0] best_reg;
    logic [AW-1:0] first_reg;
    logic        first_vld_reg;
    logic [31:0] bw_reg;
    logic [31:0] br_reg;
    logic [19:0] bp_reg;
    logic [63:0] lhs_reg;
    logic [63:0] rhs_reg;
    logic [31:0] cw_reg;
    logic [31:0] cr_reg;
    logic [1:0]  lvl_reg;
    logic [1:0]  status_reg;
    logic [30:0] cpid_reg;
    logic [1:0]  clvl_reg;
    logic [5:0]  slot_reg;
    logic        div_start_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    entry_t        ram_wdata;
    entry_t        rd;
    entry_t        wr_reg;
    logic          div_done;
    logic [31:0]   div_rem;
    logic [31:0]   lcg_next;
    logic          elig;
    logic [31:0]   wait_t;

    tlps_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd)
    );

    tlps_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (lfsr_reg),
        .divisor   (sum_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    assign m_axis_tdata  = {7'd0, slot_reg, clvl_reg, cpid_reg, status_reg};
    assign lcg_next      = lfsr_reg * LCG_MUL + LCG_ADD;
    assign elig          = rvld_reg && used_reg[ridx_reg] && rd.runnable
                           && rd.level == lvl_reg;
    assign wait_t        = now_reg - rd.arrival;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = wr_reg;
        ram_addr  = idx_reg[AW-1:0];
        case (state_reg)
            S_SELRD: ram_addr = best_reg;
            S_WRITE:
            begin
                ram_addr = best_reg;
                ram_we   = 1'b1;
            end
            S_ADDWR:
            begin
                ram_addr = best_reg;
                ram_we   = found_reg;
            end
            default: ram_addr = idx_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            lfsr_reg      <= 32'd1;
            m_axis_tvalid <= 1'b0;
            rvld_reg      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_valid)
            begin
                lfsr_reg <= cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            rvld_reg <= 1'b0;
            ridx_reg <= idx_reg[AW-1:0];
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        act_reg    <= s_axis_tdata[2:0];
                        pid_reg    <= s_axis_tdata[33:3];
                        val_reg    <= s_axis_tdata[49:34];
                        now_reg    <= s_axis_tdata[81:50];
                        state_reg  <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    status_reg    <= ST_OK;
                    cpid_reg      <= '0;
                    clvl_reg      <= '0;
                    slot_reg      <= '0;
                    idx_reg       <= '0;
                    found_reg     <= 1'b0;
                    first_vld_reg <= 1'b0;
                    sum_reg       <= '0;
                    lvl_reg       <= 2'd0;
                    if (act_reg == ACT_ADD)
                    begin
                        found_reg <= 1'b0;
                        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        begin
                            if (!used_reg[i])
                            begin
                                best_reg  <= AW'(i);
                                found_reg <= 1'b1;
                            end
                        end
                        state_reg <= S_ADDWR;
                    end
                    else if (act_reg == ACT_SCHED)
                    begin
                        rvld_reg  <= 1'b0;
                        idx_reg   <= '0;
                        ridx_reg  <= '0;
                        state_reg <= S_SUM;
                    end
                    else if (act_reg == 3'd7
                             || (act_reg == ACT_RUNNABLE && val_reg > 16'd1)
                             || (act_reg == ACT_QUEUE && val_reg > 16'd2))
                    begin
                        status_reg    <= ST_INVALID;
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        rvld_reg  <= 1'b0;
                        idx_reg   <= '0;
                        ridx_reg  <= '0;
                        state_reg <= S_FIND;
                    end
                end
                S_ADDWR: begin
                    if (!found_reg)
                    begin
                        status_reg    <= ST_FULL;
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        used_reg[best_reg] <= 1'b1;
                        slot_reg           <= 6'(best_reg);
                        m_axis_tvalid      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                S_FIND: begin
                    if (rvld_reg && used_reg[ridx_reg] && rd.pid == pid_reg)
                    begin
                        best_reg  <= ridx_reg;
                        state_reg <= S_SELRD;
                    end
                    else if (!rvld_reg && idx_reg > LAST)
                    begin
                        status_reg    <= ST_NOTFOUND;
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        rvld_reg <= idx_reg <= LAST;
                        idx_reg  <= idx_reg + (AW+1)'(1);
                    end
                end
                S_SUM: begin
                    if (elig)
                    begin
                        sum_reg <= sum_reg + 32'(rd.tickets);
                        if (!first_vld_reg)
                        begin
                            first_vld_reg <= 1'b1;
                            first_reg     <= ridx_reg;
                        end
                    end
                    if (!rvld_reg && idx_reg > LAST)
                    begin
                        if (first_vld_reg && sum_reg != 32'd0)
                        begin
                            lfsr_reg      <= lcg_next;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else if (first_vld_reg)
                        begin
                            best_reg  <= first_reg;
                            state_reg <= S_SELRD;
                        end
                        else
                        begin
                            lvl_reg   <= 2'd1;
                            idx_reg   <= '0;
                            rvld_reg  <= 1'b0;
                            ridx_reg  <= '0;
                            state_reg <= S_RATIO;
                        end
                    end
                    else
                    begin
                        rvld_reg <= idx_reg <= LAST;
                        idx_reg  <= idx_reg + (AW+1)'(1);
                    end
                end
                S_DIV: begin
                    if (div_done)
                    begin
                        r_reg     <= div_rem;
                        idx_reg   <= '0;
                        rvld_reg  <= 1'b0;
                        ridx_reg  <= '0;
                        state_reg <= S_LOT;
                    end
                end
                S_LOT: begin
                    if (elig && r_reg < 32'(rd.tickets))
                    begin
                        best_reg  <= ridx_reg;
                        state_reg <= S_SELRD;
                    end
                    else if (!rvld_reg && idx_reg > LAST)
                    begin
                        best_reg  <= first_reg;
                        state_reg <= S_SELRD;
                    end
                    else
                    begin
                        if (elig)
                        begin
                            r_reg <= r_reg - 32'(rd.tickets);
                        end
                        rvld_reg <= idx_reg <= LAST;
                        idx_reg  <= idx_reg + (AW+1)'(1);
                    end
                end
                S_RATIO: begin
                    if (elig)
                    begin
                        cw_reg    <= wait_t;
                        cr_reg    <= rd.runs;
                        lhs_reg   <= {32'd0, wait_t} * {32'd0, br_reg};
                        rhs_reg   <= {32'd0, bw_reg} * {32'd0, rd.runs};
                        best_reg  <= found_reg ? best_reg : ridx_reg;
                        first_reg <= ridx_reg;
                        state_reg <= S_RCMP;
                    end
                    else if (!rvld_reg && idx_reg > LAST)
                    begin
                        if (found_reg)
                        begin
                            lvl_reg   <= 2'd1;
                            state_reg <= S_SELRD;
                        end
                        else
                        begin
                            lvl_reg   <= 2'd2;
                            idx_reg   <= '0;
                            rvld_reg  <= 1'b0;
                            ridx_reg  <= '0;
                            state_reg <= S_PRIO;
                        end
                    end
                    else
                    begin
                        rvld_reg <= idx_reg <= LAST;
                        idx_reg  <= idx_reg + (AW+1)'(1);
                    end
                end
                S_RCMP: begin
                    if (!found_reg || lhs_reg > rhs_reg)
                    begin
                        best_reg <= first_reg;
                        bw_reg   <= cw_reg;
                        br_reg   <= cr_reg;
                    end
                    found_reg <= 1'b1;
                    // Re-read the entry at idx_reg, which was not yet examined.
                    ridx_reg  <= idx_reg[AW-1:0];
                    rvld_reg  <= idx_reg <= LAST;
                    idx_reg   <= idx_reg + (AW+1)'(1);
                    state_reg <= S_RATIO;
                end
                S_PRIO: begin
                    if (elig && (!found_reg || rd.prio < bp_reg))
                    begin
                        best_reg  <= ridx_reg;
                        bp_reg    <= rd.prio;
                        found_reg <= 1'b1;
                    end
                    if (!rvld_reg && idx_reg > LAST)
                    begin
                        if (found_reg)
                        begin
                            state_reg <= S_SELRD;
                        end
                        else
                        begin
                            status_reg    <= ST_NOTFOUND;
                            m_axis_tvalid <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        rvld_reg <= idx_reg <= LAST;
                        idx_reg  <= idx_reg + (AW+1)'(1);
                    end
                end
                S_SELRD: begin
                    state_reg <= S_SELWR;
                end
                S_SELWR: begin
                    wr_reg   <= rd;
                    slot_reg <= 6'(best_reg);
                    if (act_reg == ACT_SCHED)
                    begin
                        cpid_reg        <= rd.pid;
                        clvl_reg        <= lvl_reg;
                        wr_reg.runnable <= 1'b0;
                        if (rd.runs != 32'hFFFF_FFFF)
                        begin
                            wr_reg.runs <= rd.runs + 32'd1;
                        end
                        if (lvl_reg == 2'd2 && rd.prio != 20'd0)
                        begin
                            wr_reg.prio <= rd.prio - 20'd1;
                        end
                    end
                    else
                    begin
                        case (act_reg)
                            ACT_RUNNABLE: wr_reg.runnable <= val_reg[0];
                            ACT_REMOVE:   used_reg[best_reg] <= 1'b0;
                            ACT_QUEUE:    wr_reg.level <= val_reg[1:0];
                            ACT_TICKETS:  wr_reg.tickets <= val_reg;
                            ACT_PRIO:     wr_reg.prio <= {4'd0, val_reg} * 20'd10;
                            default:      wr_reg.runnable <= rd.runnable;
                        endcase
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    m_axis_tvalid <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_DISPATCH && act_reg == ACT_ADD)
            begin
                wr_reg.pid      <= pid_reg;
                wr_reg.runnable <= 1'b0;
                wr_reg.level    <= 2'd0;
                wr_reg.tickets  <= 16'd1;
                wr_reg.arrival  <= now_reg;
                wr_reg.runs     <= 32'd1;
                wr_reg.prio     <= 20'd10;
            end
        end
    end

endmodule
